/* sv/scrq_pkg.sv */
// Shared constants, codes and types of the slot-claim ring queue.
package scrq_pkg;

    // Field widths of the transactions and the configuration register
    localparam int KIND_W = 3;
    localparam int DATA_W = 32;
    localparam int IDX_W  = 4;
    localparam int CNT_W  = 5;
    localparam int CFG_W  = 5;

    // Build defaults
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam logic [CFG_W-1:0] MEMBER_COUNT_RST = 5'd16;

    // Operation codes
    localparam logic [KIND_W-1:0] KIND_CLAIM_TAIL   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_COMMIT_WRITE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CLAIM_HEAD   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PEEK_HEAD    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RELEASE_HEAD = 3'd4;
    localparam logic [KIND_W-1:0] KIND_COUNT_QUERY  = 3'd5;

    // Slot marks
    typedef logic [1:0] mark_t;
    localparam mark_t MARK_FREE    = 2'd0;
    localparam mark_t MARK_FILLED  = 2'd1;
    localparam mark_t MARK_READING = 2'd2;
    localparam mark_t MARK_WRITING = 2'd3;

    // Update request from the control logic to the slot store
    typedef struct packed {
        logic  mark_we;   // write a mark
        logic  at_head;   // mark goes to the head slot, else the tail slot
        mark_t mark;      // new mark
        logic  data_we;   // store the payload into the tail slot
    } slot_wr_t;

    // Marks at the current head and tail, and clearing status
    typedef struct packed {
        mark_t head_mark;
        mark_t tail_mark;
        logic  busy;
    } slot_view_t;

endpackage

/* sv/scrq_if.sv */
// Handshake channels of the slot-claim ring queue: operations in, results out.
interface scrq_op_if;
    logic                          valid;
    logic                          ready;
    logic [scrq_pkg::KIND_W-1:0]   kind;
    logic [scrq_pkg::DATA_W-1:0]   write_data;

    modport source (output valid, output kind, output write_data, input ready);
    modport sink   (input valid, input kind, input write_data, output ready);
endinterface

interface scrq_res_if;
    logic                          valid;
    logic                          ready;
    logic                          ok;
    logic [scrq_pkg::IDX_W-1:0]    slot_index;
    logic [scrq_pkg::DATA_W-1:0]   read_data;
    logic [scrq_pkg::CNT_W-1:0]    item_count;

    modport source (output valid, output ok, output slot_index, output read_data,
                    output item_count, input ready);
    modport sink   (input valid, input ok, input slot_index, input read_data,
                    input item_count, output ready);
endinterface

/* sv/scrq_slot_store.sv */
// Slot mark and payload memories with registered head/tail views and the reset clearing pass.
module scrq_slot_store #(
    parameter  int DEPTH = scrq_pkg::DEPTH_DEF,
    parameter  int SW    = scrq_pkg::DATA_W,
    localparam int PW    = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  scrq_pkg::slot_wr_t   wr,
    input  logic [PW-1:0]        head_ptr,
    input  logic [PW-1:0]        tail_ptr,
    input  logic [PW-1:0]        head_ptr_next,
    input  logic [PW-1:0]        tail_ptr_next,
    input  logic [SW-1:0]        wr_data,
    output scrq_pkg::slot_view_t view,
    output logic [SW-1:0]        head_data
);
    import scrq_pkg::*;

    mark_t           mark_mem [DEPTH];
    logic [SW-1:0]   data_mem [DEPTH];

    logic            clearing_reg;
    logic [PW-1:0]   clear_addr_reg;
    mark_t           head_mark_reg;
    mark_t           tail_mark_reg;
    logic [SW-1:0]   head_data_reg;

    logic [PW-1:0]   mark_addr;
    logic            mark_we_eff;
    logic [PW-1:0]   mark_waddr;
    mark_t           mark_wval;

    // Mark write port: the clearing pass owns it after reset
    assign mark_addr   = wr.at_head ? head_ptr : tail_ptr;
    assign mark_we_eff = clearing_reg | wr.mark_we;
    assign mark_waddr  = clearing_reg ? clear_addr_reg : mark_addr;
    assign mark_wval   = clearing_reg ? MARK_FREE : wr.mark;

    always_ff @(posedge clk)
    begin
        if (mark_we_eff)
        begin
            mark_mem[mark_waddr] <= mark_wval;
        end
    end

    // Clearing pass, one slot a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg   <= 1'b1;
            clear_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            if (clear_addr_reg == PW'(DEPTH - 1))
            begin
                clearing_reg <= 1'b0;
            end
            else
            begin
                clear_addr_reg <= clear_addr_reg + PW'(1);
            end
        end
    end

    // Registered marks at the next head and tail, forwarding this cycle's write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_mark_reg <= MARK_FREE;
            tail_mark_reg <= MARK_FREE;
        end
        else if (clearing_reg)
        begin
            head_mark_reg <= MARK_FREE;
            tail_mark_reg <= MARK_FREE;
        end
        else
        begin
            head_mark_reg <= (wr.mark_we && mark_addr == head_ptr_next) ? wr.mark
                                                                         : mark_mem[head_ptr_next];
            tail_mark_reg <= (wr.mark_we && mark_addr == tail_ptr_next) ? wr.mark
                                                                         : mark_mem[tail_ptr_next];
        end
    end

    // Payload memory: written at the tail on commit, read at the next head
    always_ff @(posedge clk)
    begin
        if (wr.data_we)
        begin
            data_mem[tail_ptr] <= wr_data;
        end
        head_data_reg <= (wr.data_we && tail_ptr == head_ptr_next) ? wr_data
                                                                   : data_mem[head_ptr_next];
    end

    assign view.head_mark = head_mark_reg;
    assign view.tail_mark = tail_mark_reg;
    assign view.busy      = clearing_reg;
    assign head_data      = head_data_reg;

endmodule

/* sv/slot_claim_ring_queue.sv */
// Top level of the slot-claim ring queue: handshakes, pointers, count and operation decode.
//
//   channel  dir  transaction                     handshake
//   op       in   kind, write_data                op.valid & op.ready
//   res      out  ok, slot_index, read_data,      res.valid & res.ready
//                 item_count
//   cfg      in   member_count                    cfg_wr_en
//
// One operation per cycle while results are taken; each transaction passes through the
// input register, then the result register, and its result is set by the single read of
// the registered head/tail slot views. After reset the slot marks are cleared, during
// which op.ready is low. A stalled result holds the result register and, through it,
// the input register; op.ready follows res.ready.
module slot_claim_ring_queue #(
    parameter int DEPTH      = scrq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = scrq_pkg::DATA_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [scrq_pkg::CFG_W-1:0]  cfg_wr_data,
    scrq_op_if.sink                     op,
    scrq_res_if.source                  res
);
    import scrq_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int RW = (CW > CFG_W) ? CW : CFG_W;
    localparam int SW = (DATA_WIDTH < DATA_W) ? DATA_WIDTH : DATA_W;

    logic [CFG_W-1:0]  member_count_reg;
    logic              s1_valid_reg;
    logic [KIND_W-1:0] s1_kind_reg;
    logic [DATA_W-1:0] s1_data_reg;
    logic [PW-1:0]     head_reg;
    logic [PW-1:0]     tail_reg;
    logic [CW-1:0]     count_reg;
    logic              res_valid_reg;
    logic              res_ok_reg;
    logic [IDX_W-1:0]  res_index_reg;
    logic [DATA_W-1:0] res_data_reg;
    logic [CNT_W-1:0]  res_count_reg;

    logic [PW-1:0]     head_next;
    logic [PW-1:0]     tail_next;
    logic [CW-1:0]     count_next;

    slot_wr_t          wr;
    slot_view_t        view;
    logic [SW-1:0]     head_data;

    logic              accept;
    logic              exec;
    logic [RW-1:0]     mc_w;
    logic [RW-1:0]     ring_size;
    logic [RW-1:0]     head_inc;
    logic [RW-1:0]     tail_inc;
    logic [PW-1:0]     head_adv;
    logic [PW-1:0]     tail_adv;
    logic              ok;
    logic              idx_head;
    logic              idx_zero;
    logic              give_data;
    logic [PW-1:0]     idx_ptr;
    logic [SW-1:0]     rdata;
    logic [PW+IDX_W-1:0]  idx_wide;
    logic [SW+DATA_W-1:0] rdata_wide;
    logic [CW+CNT_W-1:0]  cnt_wide;

    // Handshake
    assign exec     = s1_valid_reg && (!res_valid_reg || res.ready);
    assign op.ready = !view.busy && (!s1_valid_reg || exec);
    assign accept   = op.valid && op.ready;

    // Ring size clamped to 1..DEPTH, pointer advance with wrap by compare
    assign mc_w      = RW'(member_count_reg);
    assign ring_size = (mc_w == '0) ? RW'(1)
                     : ((mc_w > RW'(DEPTH)) ? RW'(DEPTH) : mc_w);
    assign head_inc  = RW'(head_reg) + RW'(1);
    assign tail_inc  = RW'(tail_reg) + RW'(1);
    assign head_adv  = (head_inc >= ring_size) ? '0 : head_inc[PW-1:0];
    assign tail_adv  = (tail_inc >= ring_size) ? '0 : tail_inc[PW-1:0];

    // Operation decode against the marks at head and tail
    always_comb
    begin
        ok         = 1'b0;
        idx_head   = 1'b0;
        idx_zero   = 1'b0;
        give_data  = 1'b0;
        wr         = '0;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        case (s1_kind_reg)
            KIND_CLAIM_TAIL:
            begin
                if (view.tail_mark == MARK_FREE)
                begin
                    ok         = 1'b1;
                    wr.mark_we = 1'b1;
                    wr.mark    = MARK_WRITING;
                end
            end
            KIND_COMMIT_WRITE:
            begin
                if (view.tail_mark == MARK_WRITING)
                begin
                    ok         = 1'b1;
                    wr.mark_we = 1'b1;
                    wr.mark    = MARK_FILLED;
                    wr.data_we = 1'b1;
                    tail_next  = tail_adv;
                    if (count_reg < CW'(DEPTH))
                    begin
                        count_next = count_reg + CW'(1);
                    end
                end
            end
            KIND_CLAIM_HEAD,
            KIND_PEEK_HEAD:
            begin
                idx_head = 1'b1;
                if (view.head_mark == MARK_FILLED)
                begin
                    ok        = 1'b1;
                    give_data = 1'b1;
                    if (s1_kind_reg == KIND_CLAIM_HEAD)
                    begin
                        wr.mark_we = 1'b1;
                        wr.at_head = 1'b1;
                        wr.mark    = MARK_READING;
                    end
                end
            end
            KIND_RELEASE_HEAD:
            begin
                idx_head = 1'b1;
                if (view.head_mark == MARK_READING)
                begin
                    ok         = 1'b1;
                    wr.mark_we = 1'b1;
                    wr.at_head = 1'b1;
                    wr.mark    = MARK_FREE;
                    head_next  = head_adv;
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
            end
            KIND_COUNT_QUERY:
            begin
                ok       = 1'b1;
                idx_zero = 1'b1;
            end
            default:
            begin
                idx_zero = 1'b1;
            end
        endcase
        if (!exec)
        begin
            wr         = '0;
            head_next  = head_reg;
            tail_next  = tail_reg;
            count_next = count_reg;
        end
    end

    // Result fields, widened or cut to the port widths
    assign idx_ptr    = idx_zero ? '0 : (idx_head ? head_reg : tail_reg);
    assign rdata      = give_data ? head_data : '0;
    assign idx_wide   = {{IDX_W{1'b0}}, idx_ptr};
    assign rdata_wide = {{DATA_W{1'b0}}, rdata};
    assign cnt_wide   = {{CNT_W{1'b0}}, count_next};

    scrq_slot_store #(
        .DEPTH (DEPTH),
        .SW    (SW)
    ) u_store (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr            (wr),
        .head_ptr      (head_reg),
        .tail_ptr      (tail_reg),
        .head_ptr_next (head_next),
        .tail_ptr_next (tail_next),
        .wr_data       (s1_data_reg[SW-1:0]),
        .view          (view),
        .head_data     (head_data)
    );

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            member_count_reg <= MEMBER_COUNT_RST;
        end
        else if (cfg_wr_en)
        begin
            member_count_reg <= cfg_wr_data;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (exec)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg <= op.kind;
            s1_data_reg <= op.write_data;
        end
    end

    // Queue pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (exec)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            res_ok_reg    <= ok;
            res_index_reg <= idx_wide[IDX_W-1:0];
            res_data_reg  <= rdata_wide[DATA_W-1:0];
            res_count_reg <= cnt_wide[CNT_W-1:0];
        end
    end

    assign res.valid      = res_valid_reg;
    assign res.ok         = res_ok_reg;
    assign res.slot_index = res_index_reg;
    assign res.read_data  = res_data_reg;
    assign res.item_count = res_count_reg;

endmodule
